FILE: design/text_terminal_line_buffer_macros.svh
// Assertion macros for the text terminal line buffer.
// Included by the top level; no other dependencies.
`ifndef TEXT_TERMINAL_LINE_BUFFER_MACROS_SVH
`define TEXT_TERMINAL_LINE_BUFFER_MACROS_SVH

`ifndef ASSERT_OFF
// Checked property, disabled while reset is asserted
`define TTLB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property, also active across reset
`define TTLB_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TTLB_ASSERT(lbl, clk, rst_n, prop, msg)
`define TTLB_ASSERT_RST(lbl, clk, prop, msg)
`endif

`endif

FILE: design/ttlb_pkg.sv
// Shared constants for the text terminal line buffer.
// No dependencies.
package ttlb_pkg;

    // CELLS_PER_LINE must be a power of two (line ends are found by shifting)
    localparam int CELLS_PER_LINE = 32;
    localparam int STORED_LINES   = 64;
    localparam int TOTAL_CELLS    = CELLS_PER_LINE * STORED_LINES;
    localparam int KEEP_CELLS     = CELLS_PER_LINE * (STORED_LINES - 1);
    localparam int LINE_SH        = $clog2(CELLS_PER_LINE);
    localparam int CUR_W          = $clog2(TOTAL_CELLS + 1);
    localparam int TOP_W          = 7;
    localparam int CELL_W         = 16;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_LEFT   = 3'd1;
    localparam logic [2:0] OP_RIGHT  = 3'd2;
    localparam logic [2:0] OP_BSPACE = 3'd3;
    localparam logic [2:0] OP_ENTER  = 3'd4;
    localparam logic [2:0] OP_SCROLL = 3'd5;

    localparam logic CFG_VISIBLE = 1'b0;
    localparam logic CFG_PROTECT = 1'b1;

endpackage

FILE: design/text_terminal_line_buffer.sv
// Text terminal line buffer: character cell store with editing sequencer.
// Depends on ttlb_pkg and text_terminal_line_buffer_macros.svh.
//
//  channel   signals                                   direction
//  command   i_in_valid / o_in_ready, i_op ...         in
//  result    o_out_valid / i_out_ready, o_cursor_pos   out
//  config    i_cfg_we, i_cfg_idx, i_cfg_data           in, write only
//
// Every command runs through one cell memory with a read and a write port,
// one cell per cycle. Insert, backspace and enter scan for the end of the
// text, then shift or clear cells; insert and enter may then drop the oldest
// line and move the view down line by line. After reset a clearing pass
// runs before the first command is taken.
`include "text_terminal_line_buffer_macros.svh"
module text_terminal_line_buffer
    import ttlb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_op,
    input  logic [7:0]        i_char_code,
    input  logic [7:0]        i_cell_flags,
    input  logic signed [7:0] i_scroll_amount,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [11:0]       o_cursor_pos,
    output logic [6:0]        o_view_offset,
    output logic [7:0]        o_cursor_char,
    output logic [7:0]        o_cursor_flags,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [7:0]        i_cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PROBE  = 4'd1;
    localparam logic [3:0] S_PCHK   = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_COPY   = 4'd4;
    localparam logic [3:0] S_CLR    = 4'd5;
    localparam logic [3:0] S_PUT    = 4'd6;
    localparam logic [3:0] S_SETTLE = 4'd7;
    localparam logic [3:0] S_DROP   = 4'd8;
    localparam logic [3:0] S_BSZ    = 4'd9;
    localparam logic [3:0] S_VIEW   = 4'd10;
    localparam logic [3:0] S_SCRL   = 4'd11;
    localparam logic [3:0] S_FIN    = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    localparam logic [CUR_W-1:0] TOTAL_C = CUR_W'(TOTAL_CELLS);
    localparam logic [CUR_W-1:0] KEEP_C  = CUR_W'(KEEP_CELLS);
    localparam logic [CUR_W-1:0] CPL_C   = CUR_W'(CELLS_PER_LINE);

    logic [CELL_W-1:0] r_mem [0:TOTAL_CELLS];
    logic [CELL_W-1:0] r_rdata;

    logic [3:0]        r_state;
    logic [3:0]        r_ret;
    logic [2:0]        r_op;
    logic [7:0]        r_ch;
    logic [7:0]        r_fl;
    logic signed [7:0] r_amt;
    logic [CUR_W-1:0]  r_cur;
    logic [TOP_W-1:0]  r_top;
    logic [6:0]        r_vis;
    logic [7:0]        r_pmask;
    logic [CUR_W-1:0]  r_e;
    logic              r_sv;
    logic              r_full;
    logic [CUR_W-1:0]  r_src;
    logic [CUR_W-1:0]  r_dst;
    logic [CUR_W-1:0]  r_wdst;
    logic [CUR_W-1:0]  r_cnt;
    logic              r_down;
    logic              r_wp;

    logic [CUR_W-1:0]  w_raddr;
    logic              w_we;
    logic [CUR_W-1:0]  w_waddr;
    logic [CELL_W-1:0] w_wdata;
    logic              w_stop;
    logic              w_scan_done;
    logic [CUR_W-1:0]  w_scan_end;
    logic [7:0]        w_vsum;
    logic              w_below;
    logic              w_prot;
    logic signed [8:0] w_ssum;
    logic [CUR_W-1:0]  w_line_end;

    // cell memory, read data registered
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    assign w_stop = r_full ? (r_rdata == '0) : (r_rdata[7:0] == 8'd0);

    always_comb begin
        w_scan_done = 1'b0;
        w_scan_end  = r_e;
        if (!r_sv) begin
            w_scan_done = (r_e == TOTAL_C);
        end else if (w_stop) begin
            w_scan_done = 1'b1;
        end else if (r_e + 1'b1 == TOTAL_C) begin
            w_scan_done = 1'b1;
            w_scan_end  = TOTAL_C;
        end
    end

    // cursor lies at or past the end of the visible window
    assign w_vsum     = {1'b0, r_vis} + {1'b0, r_top};
    assign w_below    = {1'b0, r_cur} >= {w_vsum, {LINE_SH{1'b0}}};
    assign w_prot     = (r_rdata[15:8] & r_pmask) != 8'd0;
    assign w_ssum     = $signed({2'b00, r_top}) + 9'(r_amt);
    assign w_line_end = CUR_W'(((r_e >> LINE_SH) + 1'b1) << LINE_SH);

    always_comb begin
        w_raddr = r_cur;
        w_we    = 1'b0;
        w_waddr = r_dst;
        w_wdata = '0;
        unique case (r_state)
            S_PROBE: w_raddr = (r_op == OP_BSPACE) ? r_cur - 1'b1 : r_cur;
            S_SCAN:  w_raddr = r_sv ? r_e + 1'b1 : r_e;
            S_COPY: begin
                w_raddr = r_src;
                w_we    = r_wp;
                w_waddr = r_wdst;
                w_wdata = r_rdata;
            end
            S_CLR:   w_we = (r_cnt != '0);
            S_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_cur;
                w_wdata = {r_fl, r_ch};
            end
            S_BSZ: begin
                w_we    = 1'b1;
                w_waddr = r_e;
            end
            default: ;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_ret       <= S_IDLE;
            r_dst       <= '0;
            r_cnt       <= CUR_W'(TOTAL_CELLS + 1);
            r_cur       <= '0;
            r_top       <= '0;
            r_vis       <= 7'd8;
            r_pmask     <= 8'd1;
            r_sv        <= 1'b0;
            r_wp        <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_VISIBLE: r_vis   <= i_cfg_data[6:0];
                    CFG_PROTECT: r_pmask <= i_cfg_data;
                endcase
            end
            // S_OUT itself decides the flag while a new result is loaded
            if (o_out_valid && i_out_ready && r_state != S_OUT) begin
                o_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op  <= i_op;
                        r_ch  <= i_char_code;
                        r_fl  <= i_cell_flags;
                        r_amt <= i_scroll_amount;
                        r_e   <= r_cur;
                        r_sv  <= 1'b0;
                        unique case (i_op)
                            OP_INSERT: begin
                                r_full  <= 1'b0;
                                r_state <= S_SCAN;
                            end
                            OP_LEFT, OP_RIGHT: r_state <= S_PROBE;
                            OP_BSPACE: r_state <= (r_cur == '0) ? S_FIN : S_PROBE;
                            OP_ENTER: begin
                                r_full  <= 1'b1;
                                r_state <= S_SCAN;
                            end
                            OP_SCROLL: r_state <= S_SCRL;
                            default:   r_state <= S_FIN;
                        endcase
                    end
                end
                S_PROBE: r_state <= S_PCHK;
                S_PCHK: begin
                    unique case (r_op)
                        OP_LEFT: begin
                            r_state <= S_FIN;
                            if (r_cur != '0 && !(r_cur < TOTAL_C && w_prot)) begin
                                r_cur <= r_cur - 1'b1;
                            end
                        end
                        OP_RIGHT: begin
                            r_state <= S_FIN;
                            if (r_cur < TOTAL_C && !w_prot) begin
                                r_cur <= r_cur + 1'b1;
                            end
                        end
                        default: begin
                            // backspace: the cell before the cursor was probed
                            if (!w_prot) begin
                                r_full  <= 1'b0;
                                r_state <= S_SCAN;
                            end else begin
                                r_state <= S_FIN;
                            end
                        end
                    endcase
                end
                S_SCAN: begin
                    if (w_scan_done) begin
                        r_e  <= w_scan_end;
                        r_wp <= 1'b0;
                        unique case (r_op)
                            OP_INSERT: begin
                                if (w_scan_end < TOTAL_C - 1'b1 && w_scan_end != r_cur) begin
                                    r_src   <= w_scan_end - 1'b1;
                                    r_dst   <= w_scan_end;
                                    r_cnt   <= w_scan_end - r_cur;
                                    r_down  <= 1'b1;
                                    r_ret   <= S_PUT;
                                    r_state <= S_COPY;
                                end else begin
                                    r_state <= S_PUT;
                                end
                            end
                            OP_BSPACE: begin
                                r_cur   <= r_cur - 1'b1;
                                r_src   <= r_cur;
                                r_dst   <= r_cur - 1'b1;
                                r_cnt   <= w_scan_end - r_cur + 1'b1;
                                r_down  <= 1'b0;
                                r_ret   <= S_BSZ;
                                r_state <= S_COPY;
                            end
                            default: begin
                                // enter
                                if (w_scan_end < TOTAL_C) begin
                                    r_dst   <= w_scan_end;
                                    r_cnt   <= CPL_C - CUR_W'(w_scan_end[LINE_SH-1:0]);
                                    r_ret   <= S_SETTLE;
                                    r_state <= S_CLR;
                                end else begin
                                    r_cur   <= w_scan_end;
                                    r_state <= S_SETTLE;
                                end
                            end
                        endcase
                    end else begin
                        if (r_sv) begin
                            r_e <= r_e + 1'b1;
                        end
                        r_sv <= 1'b1;
                    end
                end
                S_COPY: begin
                    if (r_cnt != '0) begin
                        r_src  <= r_down ? r_src - 1'b1 : r_src + 1'b1;
                        r_dst  <= r_down ? r_dst - 1'b1 : r_dst + 1'b1;
                        r_wdst <= r_dst;
                        r_cnt  <= r_cnt - 1'b1;
                        r_wp   <= 1'b1;
                    end else begin
                        r_wp    <= 1'b0;
                        r_state <= r_ret;
                    end
                end
                S_CLR: begin
                    if (r_cnt != '0) begin
                        r_dst <= r_dst + 1'b1;
                        r_cnt <= r_cnt - 1'b1;
                    end else begin
                        if (r_ret == S_SETTLE) begin
                            r_cur <= w_line_end;
                        end
                        r_state <= r_ret;
                    end
                end
                S_PUT: begin
                    r_cur   <= r_cur + 1'b1;
                    r_state <= S_SETTLE;
                end
                S_SETTLE: begin
                    if (r_cur >= TOTAL_C) begin
                        // drop the oldest line: move everything up one line
                        r_src   <= CPL_C;
                        r_dst   <= '0;
                        r_cnt   <= KEEP_C;
                        r_down  <= 1'b0;
                        r_wp    <= 1'b0;
                        r_ret   <= S_DROP;
                        r_state <= S_COPY;
                    end else begin
                        r_state <= S_VIEW;
                    end
                end
                S_DROP: begin
                    r_dst   <= KEEP_C;
                    r_cnt   <= CPL_C;
                    r_cur   <= KEEP_C;
                    r_ret   <= S_VIEW;
                    r_state <= S_CLR;
                end
                S_BSZ: r_state <= S_FIN;
                S_VIEW: begin
                    if (w_below) begin
                        r_top <= r_top + 1'b1;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_SCRL: begin
                    if (r_amt < 0 && w_ssum >= 0) begin
                        r_top <= w_ssum[TOP_W-1:0];
                    end else if (r_amt > 0 && w_ssum <= 9'(STORED_LINES) && w_below) begin
                        r_top <= w_ssum[TOP_W-1:0];
                    end
                    r_state <= S_FIN;
                end
                S_FIN: r_state <= S_OUT;
                S_OUT: begin
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid    <= 1'b1;
                        o_cursor_pos   <= r_cur;
                        o_view_offset  <= r_top;
                        o_cursor_char  <= r_rdata[7:0];
                        o_cursor_flags <= r_rdata[15:8];
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // an insert on the spare cell briefly leaves the cursor one past it
    `TTLB_ASSERT(a_cur_range, i_clk, i_rst_n, r_cur <= TOTAL_C + 1'b1, "cursor beyond store")
    `TTLB_ASSERT(a_wr_range, i_clk, i_rst_n, w_we |-> w_waddr <= TOTAL_C, "write beyond store")
    `TTLB_ASSERT(a_top_range, i_clk, i_rst_n, r_top <= TOP_W'(STORED_LINES + 1), "view top too large")
    `TTLB_ASSERT_RST(a_clear_busy, i_clk, !i_rst_n |=> !o_in_ready, "ready during clear pass")

endmodule
